/* design/brb_pkg.sv */
// shared constants, command codes and control/status bundles for the byte ring buffer
// used by brb_ctrl, brb_datapath and byte_ring_buffer_core
`timescale 1ns / 1ps

package brb_pkg;

   // store geometry
   localparam int DEPTH      = 4096;
   localparam int PTR_W      = 12;
   localparam int CNT_W      = 13;
   localparam int GAP        = 1;
   localparam int MAX_RUN    = 64;
   localparam int RUN_W      = 7;
   localparam int SUM_W      = 14;
   localparam int MOD_STEPS  = 14;
   localparam int MODCNT_W   = 4;
   localparam int BYTE_W     = 8;
   localparam int CMD_W      = 3;

   // ring length limits and reset value
   localparam logic [CNT_W-1:0] RING_MIN   = 13'd2;
   localparam logic [CNT_W-1:0] RING_MAX   = 13'd4096;
   localparam logic [CNT_W-1:0] RESET_SIZE = 13'd4096;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_BUFFER_SIZE = 1'b0;

   // command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_HEADER     = 3'd0,
      CMD_DATA       = 3'd1,
      CMD_DEQUEUE    = 3'd2,
      CMD_PEEK       = 3'd3,
      CMD_MOVE_FRONT = 3'd4,
      CMD_MOVE_REAR  = 3'd5,
      CMD_CLEAR      = 3'd6
   } cmd_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic exec;
      logic mod_step;
      logic rd_issue;
      logic out_status;
      logic out_byte;
   } ctl_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             run_zero;
      logic             run_last;
      logic             mod_last;
   } sts_type;

endpackage

/* design/brb_ram.sv */
// generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/brb_ctrl.sv */
// sequencing state machine for the byte ring buffer
// depends on brb_pkg; drives brb_datapath through ctl_type, reads sts_type
`timescale 1ns / 1ps

module brb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  brb_pkg::sts_type sts,
   output brb_pkg::ctl_type ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MOD,
      ST_EMIT,
      ST_RD,
      ST_RDW
   } state_type;

   state_type state_ff, state_in;
   logic      out_valid_ff, out_valid_in;
   logic      slot_free;
   logic      accept;
   brb_pkg::cmd_type cmd;

   assign cmd        = brb_pkg::cmd_type'(sts.cmd);
   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = out_valid_ff;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ctl.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            unique case (cmd)
               brb_pkg::CMD_MOVE_FRONT, brb_pkg::CMD_MOVE_REAR: state_in = ST_MOD;
               brb_pkg::CMD_DEQUEUE, brb_pkg::CMD_PEEK: begin
                  state_in = sts.run_zero ? ST_EMIT : ST_RD;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_MOD: begin
            ctl.mod_step = 1'b1;
            if (sts.mod_last) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               ctl.out_status = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_RD: begin
            ctl.rd_issue = 1'b1;
            state_in     = ST_RDW;
         end
         ST_RDW: begin
            if (slot_free) begin
               ctl.out_byte = 1'b1;
               state_in     = sts.run_last ? ST_IDLE : ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // output word valid flag
   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl.out_status || ctl.out_byte) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

/* design/brb_datapath.sv */
// pointers, occupancy arithmetic, pointer modulo unit, byte store and output word
// depends on brb_pkg and brb_ram; commanded by brb_ctrl
`timescale 1ns / 1ps

module brb_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  brb_pkg::ctl_type               ctl,
   output brb_pkg::sts_type               sts,
   input  logic [brb_pkg::CMD_W-1:0]      in_cmd,
   input  logic [brb_pkg::CNT_W-1:0]      in_length,
   input  logic [brb_pkg::BYTE_W-1:0]     in_data_byte,
   input  logic                           cfg_we,
   input  logic [brb_pkg::CNT_W-1:0]      cfg_data,
   output logic [brb_pkg::CNT_W-1:0]      cfg_size,
   output logic                           out_kind,
   output logic [brb_pkg::BYTE_W-1:0]     out_read_byte,
   output logic                           out_last,
   output logic [brb_pkg::CNT_W-1:0]      out_granted,
   output logic [brb_pkg::PTR_W-1:0]      out_position,
   output logic [brb_pkg::CNT_W-1:0]      out_used,
   output logic [brb_pkg::CNT_W-1:0]      out_free,
   output logic [brb_pkg::CNT_W-1:0]      out_direct_read,
   output logic [brb_pkg::CNT_W-1:0]      out_direct_write
);

   localparam logic [brb_pkg::CNT_W-1:0] GAP_C = brb_pkg::CNT_W'(brb_pkg::GAP);
   localparam logic [brb_pkg::CNT_W-1:0] RUN_C = brb_pkg::CNT_W'(brb_pkg::MAX_RUN);

   // configuration and pointer state
   logic [brb_pkg::CNT_W-1:0]  size_ff, slen_ff;
   logic [brb_pkg::PTR_W-1:0]  front_ff, rear_ff, rdptr_ff;
   logic [brb_pkg::CNT_W-1:0]  wrem_ff;

   // current item
   brb_pkg::cmd_type           cmd_ff;
   logic [brb_pkg::CNT_W-1:0]  len_ff;
   logic [brb_pkg::BYTE_W-1:0] dat_ff;
   logic [brb_pkg::CNT_W-1:0]  gnt_ff;
   logic [brb_pkg::PTR_W-1:0]  pos_ff;
   logic [brb_pkg::RUN_W-1:0]  nrun_ff, left_ff;

   // modulo unit
   logic [brb_pkg::SUM_W-1:0]    sum_ff;
   logic [brb_pkg::CNT_W-1:0]    rem_ff;
   logic [brb_pkg::MODCNT_W-1:0] mcnt_ff;

   // output word
   logic                       kind_ff, last_ff;
   logic [brb_pkg::BYTE_W-1:0] rbyte_ff;
   logic [brb_pkg::CNT_W-1:0]  ogrant_ff;
   logic [brb_pkg::PTR_W-1:0]  opos_ff;
   logic [brb_pkg::CNT_W-1:0]  oused_ff, ofree_ff, odr_ff, odw_ff;

   logic [brb_pkg::CNT_W-1:0]  f13, r13, used, s_minus_used, free_cnt, dr, dw;
   logic [brb_pkg::CNT_W-1:0]  fr_diff, sr_diff, gap_need;
   logic                       f_le_r;
   logic [brb_pkg::CNT_W-1:0]  len_cap, run_n, front_sum;
   logic [brb_pkg::PTR_W-1:0]  front_after_run;
   logic                       hdr_ok;
   logic [brb_pkg::SUM_W-1:0]  mod_shift;
   logic [brb_pkg::CNT_W-1:0]  rem_next;
   logic [brb_pkg::CNT_W-1:0]  rear_inc, rd_inc;
   logic [brb_pkg::PTR_W-1:0]  rear_next, rdptr_next;
   logic [brb_pkg::CNT_W-1:0]  cfg_clamp;
   logic [brb_pkg::PTR_W-1:0]  move_base;
   logic                       ram_we;
   logic [brb_pkg::BYTE_W-1:0] ram_rdata;

   // occupancy figures from the live pointers
   always_comb begin
      f13          = {1'b0, front_ff};
      r13          = {1'b0, rear_ff};
      f_le_r       = (front_ff <= rear_ff);
      used         = f_le_r ? (r13 - f13) : (slen_ff - f13 + r13);
      s_minus_used = slen_ff - used;
      free_cnt     = (s_minus_used >= GAP_C) ? (s_minus_used - GAP_C) : '0;
      dr           = f_le_r ? (r13 - f13) : (slen_ff - f13);
      fr_diff      = f13 - r13;
      sr_diff      = slen_ff - r13;
      gap_need     = GAP_C - f13;
      if (rear_ff < front_ff) begin
         dw = (fr_diff >= GAP_C) ? (fr_diff - GAP_C) : '0;
      end else if (f13 < GAP_C) begin
         dw = (sr_diff >= gap_need) ? (sr_diff - gap_need) : '0;
      end else begin
         dw = sr_diff;
      end
   end

   // header check and read run length
   always_comb begin
      hdr_ok          = (len_ff != '0) && (len_ff <= free_cnt);
      len_cap         = (len_ff > RUN_C) ? RUN_C : len_ff;
      run_n           = (len_cap > used) ? used : len_cap;
      front_sum       = f13 + run_n;
      front_after_run = (front_sum >= slen_ff) ? brb_pkg::PTR_W'(front_sum - slen_ff)
                                               : front_sum[brb_pkg::PTR_W-1:0];
   end

   // single-step pointer increments with wrap at the ring end
   always_comb begin
      rear_inc   = r13 + 13'd1;
      rear_next  = (rear_inc == slen_ff) ? '0 : rear_inc[brb_pkg::PTR_W-1:0];
      rd_inc     = {1'b0, rdptr_ff} + 13'd1;
      rdptr_next = (rd_inc == slen_ff) ? '0 : rd_inc[brb_pkg::PTR_W-1:0];
   end

   // one restoring remainder step per cycle
   always_comb begin
      mod_shift = {rem_ff, sum_ff[brb_pkg::SUM_W-1]};
      rem_next  = (mod_shift >= {1'b0, slen_ff}) ? brb_pkg::CNT_W'(mod_shift - {1'b0, slen_ff})
                                                  : mod_shift[brb_pkg::CNT_W-1:0];
   end

   // ring length clamp for a new size value
   always_comb begin
      if (cfg_data < brb_pkg::RING_MIN) begin
         cfg_clamp = brb_pkg::RING_MIN;
      end else if (cfg_data > brb_pkg::RING_MAX) begin
         cfg_clamp = brb_pkg::RING_MAX;
      end else begin
         cfg_clamp = cfg_data;
      end
   end

   assign move_base = (cmd_ff == brb_pkg::CMD_MOVE_FRONT) ? front_ff : rear_ff;
   assign ram_we    = ctl.exec && (cmd_ff == brb_pkg::CMD_DATA) && (wrem_ff != '0);

   // control state: size, pointers, open enqueue count
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= brb_pkg::RESET_SIZE;
         slen_ff  <= brb_pkg::RESET_SIZE;
         front_ff <= '0;
         rear_ff  <= '0;
         wrem_ff  <= '0;
      end else if (cfg_we) begin
         size_ff  <= cfg_data;
         slen_ff  <= cfg_clamp;
         front_ff <= '0;
         rear_ff  <= '0;
         wrem_ff  <= '0;
      end else if (ctl.exec) begin
         unique case (cmd_ff)
            brb_pkg::CMD_HEADER: wrem_ff <= hdr_ok ? len_ff : '0;
            brb_pkg::CMD_DATA: begin
               if (wrem_ff != '0) begin
                  rear_ff <= rear_next;
                  wrem_ff <= wrem_ff - 13'd1;
               end
            end
            brb_pkg::CMD_DEQUEUE: front_ff <= front_after_run;
            brb_pkg::CMD_CLEAR: begin
               front_ff <= '0;
               rear_ff  <= '0;
               wrem_ff  <= '0;
            end
            default: ;
         endcase
      end else if (ctl.mod_step && (mcnt_ff == '0)) begin
         if (cmd_ff == brb_pkg::CMD_MOVE_FRONT) begin
            front_ff <= rem_next[brb_pkg::PTR_W-1:0];
         end else begin
            rear_ff <= rem_next[brb_pkg::PTR_W-1:0];
         end
      end
   end

   // item registers, modulo unit and read run
   always_ff @(posedge clock) begin
      if (ctl.load_item) begin
         cmd_ff <= brb_pkg::cmd_type'(in_cmd);
         len_ff <= in_length;
         dat_ff <= in_data_byte;
      end
      if (ctl.exec) begin
         pos_ff  <= '0;
         sum_ff  <= brb_pkg::SUM_W'(move_base) + brb_pkg::SUM_W'(len_ff);
         rem_ff  <= '0;
         mcnt_ff <= brb_pkg::MODCNT_W'(brb_pkg::MOD_STEPS - 1);
         nrun_ff <= run_n[brb_pkg::RUN_W-1:0];
         left_ff <= run_n[brb_pkg::RUN_W-1:0];
         rdptr_ff <= front_ff;
         unique case (cmd_ff)
            brb_pkg::CMD_HEADER: gnt_ff <= hdr_ok ? len_ff : '0;
            brb_pkg::CMD_DATA:   gnt_ff <= (wrem_ff != '0) ? 13'd1 : '0;
            brb_pkg::CMD_DEQUEUE, brb_pkg::CMD_PEEK: gnt_ff <= run_n;
            default: gnt_ff <= '0;
         endcase
      end
      if (ctl.mod_step) begin
         sum_ff  <= {sum_ff[brb_pkg::SUM_W-2:0], 1'b0};
         rem_ff  <= rem_next;
         mcnt_ff <= mcnt_ff - 4'd1;
         if (mcnt_ff == '0) begin
            pos_ff <= rem_next[brb_pkg::PTR_W-1:0];
         end
      end
      if (ctl.rd_issue) begin
         rdptr_ff <= rdptr_next;
      end
      if (ctl.out_byte) begin
         left_ff <= left_ff - 7'd1;
      end
   end

   // output word
   always_ff @(posedge clock) begin
      if (ctl.out_status || ctl.out_byte) begin
         oused_ff <= used;
         ofree_ff <= free_cnt;
         odr_ff   <= dr;
         odw_ff   <= dw;
      end
      if (ctl.out_status) begin
         kind_ff   <= 1'b0;
         rbyte_ff  <= '0;
         last_ff   <= 1'b1;
         ogrant_ff <= gnt_ff;
         opos_ff   <= pos_ff;
      end else if (ctl.out_byte) begin
         kind_ff   <= 1'b1;
         rbyte_ff  <= ram_rdata;
         last_ff   <= (left_ff == 7'd1);
         ogrant_ff <= brb_pkg::CNT_W'(nrun_ff);
         opos_ff   <= '0;
      end
   end

   // byte store
   brb_ram #(
      .WIDTH(brb_pkg::BYTE_W),
      .DEPTH(brb_pkg::DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(rear_ff),
      .wr_data(dat_ff),
      .rd_en  (ctl.rd_issue),
      .rd_addr(rdptr_ff),
      .rd_data(ram_rdata)
   );

   // status toward the controller
   assign sts.cmd      = cmd_ff;
   assign sts.run_zero = (run_n == '0);
   assign sts.run_last = (left_ff == 7'd1);
   assign sts.mod_last = (mcnt_ff == '0);

   assign cfg_size         = size_ff;
   assign out_kind         = kind_ff;
   assign out_read_byte    = rbyte_ff;
   assign out_last         = last_ff;
   assign out_granted      = ogrant_ff;
   assign out_position     = opos_ff;
   assign out_used         = oused_ff;
   assign out_free         = ofree_ff;
   assign out_direct_read  = odr_ff;
   assign out_direct_write = odw_ff;

endmodule

/* design/byte_ring_buffer_core.sv */
// Circular byte FIFO with a reserved one-slot gap, driven by a command stream.
// Request words: tuser = cmd; tdata = length, data_byte. Each request yields one
// response word (status) or, for dequeue and peek, one word per byte delivered
// (tuser = kind, tlast on the final word). Every response carries granted count,
// new pointer after a move, and used/free/contiguous read/contiguous write sizes
// taken after the command.
// Sequence: header, data byte, clear and unused commands pass from accept through
// the execute and emit states to the response; moves add a 14-step one-bit-per-cycle
// remainder unit that wraps the pointer modulo the ring length; dequeue and peek
// issue one store read per byte and return each byte as its own response word.
// One request is in flight at a time; a new request is accepted once the last
// response word of the previous one is in the output register.
// A stalled receiver holds the output word; work waits until the register frees.
// Reset (synchronous) empties the ring, closes any open enqueue and sets the
// ring length to 4096. Writing buffer_size (byte 0 of the APB port) does the
// same with the new length, clamped to 2..4096. Store contents are not cleared.
`timescale 1ns / 1ps

module byte_ring_buffer_core (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // length[12:0], data_byte[20:13], zero pad
   input  logic [2:0]                       req_tuser,  // cmd[2:0]
   // response stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [87:0]                      rsp_tdata,  // read_byte[7:0], granted[20:8],
                                                        // position[32:21], used_count[45:33],
                                                        // free_count[58:46], direct_read[71:59],
                                                        // direct_write[84:72], zero pad
   output logic                             rsp_tuser,  // kind
   output logic                             rsp_tlast,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [brb_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [brb_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [brb_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);

   brb_pkg::ctl_type ctl;
   brb_pkg::sts_type sts;
   logic                           cfg_we;
   logic                           reg_sel;
   logic [brb_pkg::CNT_W-1:0]      cfg_size;
   logic                           out_kind, out_last;
   logic [brb_pkg::BYTE_W-1:0]     out_read_byte;
   logic [brb_pkg::CNT_W-1:0]      out_granted, out_used, out_free, out_dr, out_dw;
   logic [brb_pkg::PTR_W-1:0]      out_position;

   // register decode
   assign reg_sel    = (csr_paddr[2] == brb_pkg::REG_BUFFER_SIZE);
   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_sel;
   assign csr_prdata = reg_sel ? brb_pkg::CSR_DATA_W'(cfg_size) : '0;

   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .sts       (sts),
      .ctl       (ctl)
   );

   brb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .in_cmd          (req_tuser),
      .in_length       (req_tdata[12:0]),
      .in_data_byte    (req_tdata[20:13]),
      .cfg_we          (cfg_we),
      .cfg_data        (csr_pwdata[12:0]),
      .cfg_size        (cfg_size),
      .out_kind        (out_kind),
      .out_read_byte   (out_read_byte),
      .out_last        (out_last),
      .out_granted     (out_granted),
      .out_position    (out_position),
      .out_used        (out_used),
      .out_free        (out_free),
      .out_direct_read (out_dr),
      .out_direct_write(out_dw)
   );

   // response word packing
   assign rsp_tdata = {3'b000, out_dw, out_dr, out_free, out_used,
                       out_position, out_granted, out_read_byte};
   assign rsp_tuser = out_kind;
   assign rsp_tlast = out_last;

endmodule

/* dv/tb_byte_ring_buffer_core.sv */
// self-checking testbench for byte_ring_buffer_core: drives command words, mirrors the ring
// in a local model and compares every response word; depends on brb_pkg and the core only
`timescale 1ns / 1ps

module tb_byte_ring_buffer_core;
   import brb_pkg::*;

   localparam logic [CMD_W-1:0]      CMD_UNUSED       = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] ADDR_BUFFER_SIZE = CSR_ADDR_W'(4 * int'(REG_BUFFER_SIZE));
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CNT_W-1:0]  len;
      logic [BYTE_W-1:0] dat;
   } ring_cmd_type;

   typedef struct packed {
      logic [PTR_W-1:0] front;
      logic [PTR_W-1:0] rear;
      logic [CNT_W-1:0] remaining;
      logic [CNT_W-1:0] ring;
   } ring_ptrs_type;

   typedef struct packed {
      logic              kind;
      logic [BYTE_W-1:0] rbyte;
      logic              last;
      logic [CNT_W-1:0]  granted;
      logic [PTR_W-1:0]  position;
      logic [CNT_W-1:0]  used, free, dread, dwrite;
   } rsp_word_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata   = '0;
   logic [2:0]            req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [87:0]           rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // ring mirror updated on accepted commands
   ring_ptrs_type  model_ptrs;
   logic [7:0]     model_bytes [0:DEPTH-1];
   // stimulus-side shadow, keeps reads away from never-written slots
   ring_ptrs_type  plan_ptrs;
   bit             plan_written [0:DEPTH-1];

   ring_cmd_type   queued_commands [$];
   rsp_word_type   awaited_words [$];
   ring_cmd_type   on_bus;
   rsp_word_type   want;
   int          useful_items   = 0;
   int          mismatch_count = 0;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   int          hold_left      = 0;
   logic        hold_kick      = 1'b0;

   byte_ring_buffer_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // length[12:0], data_byte[20:13], zero pad
      .req_tuser   (req_tuser),   // cmd[2:0]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // read_byte, granted, position, used, free, direct_read,
                                  // direct_write, zero pad
      .rsp_tuser   (rsp_tuser),   // kind
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // occupancy helpers
   function automatic int used_of(input ring_ptrs_type st);
      int f, r, s;
      f = int'(st.front);
      r = int'(st.rear);
      s = int'(st.ring);
      return (f <= r) ? r - f : s - f + r;
   endfunction

   function automatic int free_of(input ring_ptrs_type st);
      int v;
      v = int'(st.ring) - used_of(st) - GAP;
      return (v < 0) ? 0 : v;
   endfunction

   function automatic int dread_of(input ring_ptrs_type st);
      return (st.front <= st.rear) ? int'(st.rear) - int'(st.front)
                                   : int'(st.ring) - int'(st.front);
   endfunction

   function automatic int dwrite_of(input ring_ptrs_type st);
      int f, r, s, d;
      f = int'(st.front);
      r = int'(st.rear);
      s = int'(st.ring);
      if (r < f) d = (f - r) - GAP;
      else if (f < GAP) d = (s - r) - (GAP - f);
      else d = s - r;
      return (d < 0) ? 0 : d;
   endfunction

   // read run: request cut to the run limit and to the bytes held
   function automatic int run_of(input ring_ptrs_type st, input int len);
      int n;
      n = len;
      if (n > MAX_RUN) n = MAX_RUN;
      if (n > used_of(st)) n = used_of(st);
      return n;
   endfunction

   function automatic logic [PTR_W-1:0] wrap_add(input ring_ptrs_type st, input int p,
                                                 input int n);
      return PTR_W'((p + n) % int'(st.ring));
   endfunction

   function automatic ring_ptrs_type ring_after_config(input logic [CNT_W-1:0] value);
      ring_ptrs_type st;
      st.front     = '0;
      st.rear      = '0;
      st.remaining = '0;
      if (value < RING_MIN) st.ring = RING_MIN;
      else if (value > RING_MAX) st.ring = RING_MAX;
      else st.ring = value;
      return st;
   endfunction

   function automatic int granted_of(input ring_ptrs_type st, input logic [CMD_W-1:0] cmd,
                                     input int len);
      case (cmd)
         CMD_HEADER:            return (len == 0 || len > free_of(st)) ? 0 : len;
         CMD_DATA:              return (st.remaining != 0) ? 1 : 0;
         CMD_DEQUEUE, CMD_PEEK: return run_of(st, len);
         default:               return 0;
      endcase
   endfunction

   // pointer and enqueue state after one command
   function automatic ring_ptrs_type ring_after_cmd(input ring_ptrs_type st,
                                                    input logic [CMD_W-1:0] cmd,
                                                    input int len);
      ring_ptrs_type nx;
      nx = st;
      case (cmd)
         CMD_HEADER: begin
            nx.remaining = (len == 0 || len > free_of(st)) ? '0 : CNT_W'(len);
         end
         CMD_DATA: begin
            if (st.remaining != 0) begin
               nx.rear      = wrap_add(st, int'(st.rear), 1);
               nx.remaining = st.remaining - CNT_W'(1);
            end
         end
         CMD_DEQUEUE:    nx.front = wrap_add(st, int'(st.front), run_of(st, len));
         CMD_MOVE_FRONT: nx.front = wrap_add(st, int'(st.front), len);
         CMD_MOVE_REAR:  nx.rear  = wrap_add(st, int'(st.rear), len);
         CMD_CLEAR: begin
            nx.front     = '0;
            nx.rear      = '0;
            nx.remaining = '0;
         end
         default: ;
      endcase
      return nx;
   endfunction

   // response words caused by one accepted command word
   task automatic compute_response_words(input ring_cmd_type c);
      ring_ptrs_type nx;
      rsp_word_type  w;
      logic [7:0] run_bytes [0:MAX_RUN-1];
      int         n, g, k;
      n = 0;
      if (c.cmd == CMD_DEQUEUE || c.cmd == CMD_PEEK) n = run_of(model_ptrs, int'(c.len));
      for (k = 0; k < n; k++)
         run_bytes[k] = model_bytes[(int'(model_ptrs.front) + k) % int'(model_ptrs.ring)];
      if (c.cmd == CMD_DATA && model_ptrs.remaining != 0) model_bytes[model_ptrs.rear] = c.dat;
      g = granted_of(model_ptrs, c.cmd, int'(c.len));
      nx = ring_after_cmd(model_ptrs, c.cmd, int'(c.len));
      model_ptrs = nx;

      w.used   = CNT_W'(used_of(nx));
      w.free   = CNT_W'(free_of(nx));
      w.dread  = CNT_W'(dread_of(nx));
      w.dwrite = CNT_W'(dwrite_of(nx));
      if (n == 0) begin
         w.kind    = 1'b0;
         w.rbyte   = '0;
         w.last    = 1'b1;
         w.granted = CNT_W'(g);
         if (c.cmd == CMD_MOVE_FRONT) w.position = nx.front;
         else if (c.cmd == CMD_MOVE_REAR) w.position = nx.rear;
         else w.position = '0;
         awaited_words.push_back(w);
      end else begin
         for (k = 0; k < n; k++) begin
            w.kind     = 1'b1;
            w.rbyte    = run_bytes[k];
            w.last     = (k == n - 1);
            w.granted  = CNT_W'(n);
            w.position = '0;
            awaited_words.push_back(w);
         end
      end
   endtask

   // queue one command word, clipping reads that would touch never-written slots
   task automatic queue_command(input logic [CMD_W-1:0] cmd, input int len, input int dat);
      ring_cmd_type c;
      int        n, k;
      c.cmd = cmd;
      c.len = CNT_W'(len);
      c.dat = BYTE_W'(dat);
      if (cmd == CMD_DEQUEUE || cmd == CMD_PEEK) begin
         n = run_of(plan_ptrs, int'(c.len));
         k = 0;
         while (k < n && plan_written[(int'(plan_ptrs.front) + k) % int'(plan_ptrs.ring)])
            k++;
         if (k < n) c.len = CNT_W'(k);
      end
      if (cmd == CMD_DATA && plan_ptrs.remaining != 0) plan_written[plan_ptrs.rear] = 1'b1;
      // stray data words are dropped by the block and do not count
      if (!(cmd == CMD_DATA && plan_ptrs.remaining == 0)) useful_items++;
      plan_ptrs = ring_after_cmd(plan_ptrs, cmd, int'(c.len));
      queued_commands.push_back(c);
   endtask

   // random mix, mostly complete enqueues and reads
   task automatic mixed_traffic(input int target);
      int start, pick, len, fr, cap, k;
      start = useful_items;
      while (useful_items - start < target) begin
         pick = $urandom_range(0, 99);
         fr   = free_of(plan_ptrs);
         if (pick < 45) begin
            if (fr == 0) begin
               queue_command(CMD_HEADER, $urandom_range(1, 8191), $urandom_range(0, 255));
            end else begin
               cap = ($urandom_range(0, 7) == 0) ? 64 : 24;
               if (cap > fr) cap = fr;
               len = $urandom_range(1, cap);
               queue_command(CMD_HEADER, len, $urandom_range(0, 255));
               // sometimes the enqueue is broken off early
               if ($urandom_range(0, 9) == 0) len = $urandom_range(0, len - 1);
               for (k = 0; k < len; k++)
                  queue_command(CMD_DATA, $urandom_range(0, 8191), $urandom_range(0, 255));
            end
         end else if (pick < 75) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 70);
            queue_command(($urandom_range(0, 1) == 0) ? CMD_DEQUEUE : CMD_PEEK, len,
                          $urandom_range(0, 255));
         end else if (pick < 83) begin
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                              : $urandom_range(0, int'(plan_ptrs.ring) + 3);
            queue_command(($urandom_range(0, 1) == 0) ? CMD_MOVE_FRONT : CMD_MOVE_REAR, len,
                          $urandom_range(0, 255));
         end else if (pick < 88) begin
            queue_command(CMD_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 255));
         end else if (pick < 94) begin
            // refused header, then a data word that finds no open enqueue
            len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(fr + 1, 8191);
            queue_command(CMD_HEADER, len, $urandom_range(0, 255));
            queue_command(CMD_DATA, $urandom_range(0, 8191), $urandom_range(0, 255));
         end else begin
            queue_command(($urandom_range(0, 1) == 0) ? CMD_UNUSED : CMD_DATA,
                          $urandom_range(0, 8191), $urandom_range(0, 255));
         end
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (queued_commands.size() != 0 || req_tvalid || awaited_words.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // apb write of buffer_size: setup cycle, then access cycle
   task automatic write_ring_size(input logic [CNT_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_BUFFER_SIZE;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      model_ptrs = ring_after_config(value);
      plan_ptrs  = ring_after_config(value);
      @(negedge clock);
   endtask

   task automatic next_setting(input logic [CNT_W-1:0] value, input int send_pct,
                               input int recv_pct);
      wait_idle();
      write_ring_size(value);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   task automatic check_field(input string name, input int expected, input int actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, expected, actual);
         mismatch_count++;
      end
   endtask

   // command driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) compute_response_words(on_bus);
         if (!req_tvalid || req_tready) begin
            if (queued_commands.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               on_bus = queued_commands.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= on_bus.cmd;
               req_tdata  <= {3'b000, on_bus.dat, on_bus.len};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_kick) hold_left <= HOLD_CYCLES;
      else if (hold_left != 0) hold_left <= hold_left - 1;
   end

   // response monitor and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_words.size() == 0) begin
            $display("%0t: response word expected none actual tdata %h tuser %b tlast %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = awaited_words.pop_front();
            check_field("kind", int'(want.kind), int'(rsp_tuser));
            check_field("read_byte", int'(want.rbyte), int'(rsp_tdata[7:0]));
            check_field("last", int'(want.last), int'(rsp_tlast));
            check_field("granted", int'(want.granted), int'(rsp_tdata[20:8]));
            check_field("position", int'(want.position), int'(rsp_tdata[32:21]));
            check_field("used_count", int'(want.used), int'(rsp_tdata[45:33]));
            check_field("free_count", int'(want.free), int'(rsp_tdata[58:46]));
            check_field("direct_read", int'(want.dread), int'(rsp_tdata[71:59]));
            check_field("direct_write", int'(want.dwrite), int'(rsp_tdata[84:72]));
         end
      end
      rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      model_ptrs = ring_after_config(RESET_SIZE);
      plan_ptrs  = ring_after_config(RESET_SIZE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty read, stray data, refused headers, reopened enqueue, long peek
      queue_command(CMD_PEEK, 0, 0);
      queue_command(CMD_DATA, 0, 8'hA5);
      queue_command(CMD_HEADER, 0, 0);
      queue_command(CMD_HEADER, 4096, 0);
      queue_command(CMD_HEADER, 8191, 0);
      queue_command(CMD_HEADER, 6, 8'hFF);
      queue_command(CMD_DATA, 0, 8'h00);
      queue_command(CMD_DATA, 8191, 8'hFF);
      queue_command(CMD_HEADER, 3, 0);
      queue_command(CMD_DATA, 1, 8'h5A);
      queue_command(CMD_DATA, 2, 8'hC3);
      queue_command(CMD_DATA, 3, 8'h0F);
      queue_command(CMD_DATA, 4, 8'hF0);
      queue_command(CMD_PEEK, 4096, 0);
      queue_command(CMD_DEQUEUE, 2, 0);
      queue_command(CMD_UNUSED, 8191, 8'hFF);
      queue_command(CMD_CLEAR, 0, 0);
      mixed_traffic(8);

      // small ring: moves past the end, rear and front wrap
      next_setting(13'd5, 0, 0);
      queue_command(CMD_MOVE_FRONT, 8188, 0);
      queue_command(CMD_MOVE_REAR, 3, 0);
      queue_command(CMD_HEADER, 3, 0);
      queue_command(CMD_DATA, 0, 8'h11);
      queue_command(CMD_DATA, 0, 8'h22);
      queue_command(CMD_DATA, 0, 8'h33);
      queue_command(CMD_DEQUEUE, 64, 0);
      mixed_traffic(8);

      next_setting(13'd2, 59, 0);
      mixed_traffic(7);
      next_setting(13'd8191, 0, 59);
      mixed_traffic(7);
      next_setting(13'd0, 19, 19);
      mixed_traffic(7);

      // receiver held off while the sender keeps offering
      next_setting(13'd100, 0, 0);
      queue_command(CMD_HEADER, 20, 0);
      repeat (20) queue_command(CMD_DATA, $urandom_range(0, 8191), $urandom_range(0, 255));
      queue_command(CMD_HEADER, 10, 0);
      repeat (10) queue_command(CMD_DATA, $urandom_range(0, 8191), $urandom_range(0, 255));
      queue_command(CMD_PEEK, 64, 0);
      queue_command(CMD_DEQUEUE, 64, 0);
      queue_command(CMD_DEQUEUE, 40, 0);
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      @(negedge clock);
      mixed_traffic(7);

      next_setting(13'd1, 59, 0);
      mixed_traffic(6);
      next_setting(13'd4096, 19, 19);
      mixed_traffic(7);
      next_setting(13'd17, 0, 59);
      mixed_traffic(7);

      wait_idle();
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

/* filelist.f */
design/brb_pkg.sv
design/brb_ram.sv
design/brb_ctrl.sv
design/brb_datapath.sv
design/byte_ring_buffer_core.sv
dv/tb_byte_ring_buffer_core.sv
